@@ design/hpq_pkg.sv @@
// shared types, constants and helpers for the binary heap priority queue
// no dependencies; imported by the top level, hpq_ctrl and hpq_dp (hpq_ram does not use it)
package hpq_pkg;

  localparam int CAPACITY     = 64;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 32;

  localparam int FIELD_W   = 32;
  localparam int OUT_CNT_W = 7;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = ($clog2(CAPACITY + 1) > OUT_CNT_W) ? $clog2(CAPACITY + 1)
                                                                 : OUT_CNT_W;
  localparam int CHILD_W   = CNT_W + 1;
  localparam int ENTRY_W   = KEY_BITS + PAYLOAD_BITS;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int CMD_W = 4;
  localparam logic [CMD_W-1:0] CMD_IDLE     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_ACCEPT   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_DISP     = 4'd2;
  localparam logic [CMD_W-1:0] CMD_UP       = 4'd3;
  localparam logic [CMD_W-1:0] CMD_UP_CMP   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_POP_TOP  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_POP_LAST = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DN_L     = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DN_R     = 4'd8;
  localparam logic [CMD_W-1:0] CMD_DN_C     = 4'd9;
  localparam logic [CMD_W-1:0] CMD_RESULT   = 4'd10;

  typedef struct packed {
    logic               operation;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 top_valid;
    logic [FIELD_W-1:0]   top_key;
    logic [FIELD_W-1:0]   top_payload;
    logic [OUT_CNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic [CMD_W-1:0] code;
  } hpq_cmd_t;

  typedef struct packed {
    logic refuse;    // item is refused or pops an empty queue
    logic is_pop;
    logic at_root;
    logic up_swap;
    logic dn_leaf;
    logic dn_stay;
    logic out_free;
  } hpq_stat_t;

  // true when key a should sit above key b
  function automatic logic beats(input logic mode, input logic [KEY_BITS-1:0] a,
                                 input logic [KEY_BITS-1:0] b);
    beats = mode ? (a > b) : (a < b);
  endfunction

endpackage

@@ design/binary_heap_priority_queue.sv @@
// top level of the binary heap priority queue: controller plus datapath
// depends on hpq_pkg, hpq_ctrl, hpq_dp (which holds hpq_ram)
//
// Priority queue kept as a binary heap in a 64-entry ram (one write port, one
// registered read port). Each input transfer is an insert (key plus payload) or a
// pop; each produces exactly one result transfer carrying a status (done, insert
// refused because full, pop from empty), the popped key and payload when there is
// one (zero otherwise) and the entry count after the operation. cfg_wdata written
// with cfg_we picks the order: 0 serves the smallest key first, 1 the largest;
// change it only while idle, the held entries are not reordered. Equal keys never
// swap. One item is worked at a time. The single ram read port sets the rate: an
// insert reads one parent per level it climbs, a pop reads the root and the last
// entry, then both children per level it descends, and refused items skip the
// heap. A finished result sits in an output register, so a new input transfer is
// taken while the result still waits for out_ready. The heap ram needs no clearing
// after reset: only entries in slots below the fill count are used.
module binary_heap_priority_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hpq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hpq_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import hpq_pkg::*;

  // command and status between sequencer and datapath
  hpq_cmd_t  cmd;
  hpq_stat_t stat;

  hpq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // heap storage, sift registers and the output register
  hpq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

@@ design/hpq_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module hpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/hpq_dp.sv @@
// datapath of the heap queue: heap ram, moving entry, hole index, fill count, result register
// depends on hpq_pkg and hpq_ram
module hpq_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  hpq_pkg::hpq_cmd_t cmd,
  output hpq_pkg::hpq_stat_t stat,
  input  hpq_pkg::in_item_t in_data,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  output logic              out_valid,
  input  logic              out_ready,
  output hpq_pkg::out_item_t out_data
);
  import hpq_pkg::*;

  logic             mode_r, mode_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] hole_r, hole_nxt;
  logic [IDX_W-1:0] best_r, best_nxt;
  entry_t           mov_r, mov_nxt;
  entry_t           best_e_r, best_e_nxt;
  entry_t           top_r, top_nxt;
  logic             op_r, op_nxt;
  logic [1:0]       st_r, st_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, rd_e;

  logic [IDX_W-1:0]   parent_idx, fin_idx;
  logic [CHILD_W-1:0] left_w, right_w;
  logic               right_ok, take_left, take_right, full, empty, top_ok;
  entry_t             in_e, fin_e;

  hpq_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_e)
  );

  // tree geometry around the hole
  assign parent_idx = (hole_r - IDX_W'(1)) >> 1;
  assign left_w     = (CHILD_W'(hole_r) << 1) + CHILD_W'(1);
  assign right_w    = left_w + CHILD_W'(1);
  assign right_ok   = right_w < CHILD_W'(fill_r);
  assign full       = fill_r >= CNT_W'(CAPACITY);
  assign empty      = fill_r == '0;

  assign in_e.key     = in_data.key[KEY_BITS-1:0];
  assign in_e.payload = in_data.payload[PAYLOAD_BITS-1:0];

  // left child read last cycle against moving entry, right child now against the winner
  assign take_left  = beats(mode_r, rd_e.key, mov_r.key);
  assign take_right = right_ok && beats(mode_r, rd_e.key, best_e_r.key);
  assign fin_idx    = take_right ? right_w[IDX_W-1:0] : best_r;
  assign fin_e      = take_right ? rd_e : best_e_r;
  assign top_ok     = (op_r == OP_POP) && (st_r == ST_DONE);

  assign stat.refuse   = st_r != ST_DONE;
  assign stat.is_pop   = op_r == OP_POP;
  assign stat.at_root  = hole_r == '0;
  assign stat.up_swap  = beats(mode_r, mov_r.key, rd_e.key);
  assign stat.dn_leaf  = left_w >= CHILD_W'(fill_r);
  assign stat.dn_stay  = fin_idx == hole_r;
  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    mode_nxt      = cfg_we ? cfg_wdata : mode_r;
    fill_nxt      = fill_r;
    hole_nxt      = hole_r;
    best_nxt      = best_r;
    mov_nxt       = mov_r;
    best_e_nxt    = best_e_r;
    top_nxt       = top_r;
    op_nxt        = op_r;
    st_nxt        = st_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = hole_r;
    ram_wdata     = mov_r;
    ram_raddr     = hole_r;
    unique case (cmd.code)
      CMD_ACCEPT: begin
        op_nxt  = in_data.operation;
        top_nxt = '0;
        if (in_data.operation == OP_INSERT) begin
          if (full) begin
            st_nxt = ST_FULL;
          end else begin
            st_nxt   = ST_DONE;
            mov_nxt  = in_e;
            hole_nxt = fill_r[IDX_W-1:0];
            fill_nxt = fill_r + CNT_W'(1);
          end
        end else begin
          if (empty) begin
            st_nxt = ST_EMPTY;
          end else begin
            st_nxt   = ST_DONE;
            // hole parks at the last slot until the root is read
            hole_nxt = IDX_W'(fill_r - CNT_W'(1));
            fill_nxt = fill_r - CNT_W'(1);
          end
        end
      end
      CMD_DISP: begin
        ram_raddr = '0;
      end
      CMD_UP: begin
        if (hole_r == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_raddr = parent_idx;
        end
      end
      CMD_UP_CMP: begin
        ram_we = 1'b1;
        if (stat.up_swap) begin
          ram_wdata = rd_e;
          hole_nxt  = parent_idx;
        end
      end
      CMD_POP_TOP: begin
        top_nxt   = rd_e;
        ram_raddr = hole_r;
      end
      CMD_POP_LAST: begin
        mov_nxt  = rd_e;
        hole_nxt = '0;
      end
      CMD_DN_L: begin
        if (stat.dn_leaf) begin
          ram_we = 1'b1;
        end else begin
          ram_raddr = left_w[IDX_W-1:0];
        end
      end
      CMD_DN_R: begin
        ram_raddr = right_w[IDX_W-1:0];
        if (take_left) begin
          best_nxt   = left_w[IDX_W-1:0];
          best_e_nxt = rd_e;
        end else begin
          best_nxt   = hole_r;
          best_e_nxt = mov_r;
        end
      end
      CMD_DN_C: begin
        ram_we = 1'b1;
        if (!stat.dn_stay) begin
          ram_wdata = fin_e;
          hole_nxt  = fin_idx;
        end
      end
      CMD_RESULT: begin
        out_nxt.status      = st_r;
        out_nxt.top_valid   = top_ok;
        out_nxt.top_key     = FIELD_W'(top_r.key);
        out_nxt.top_payload = FIELD_W'(top_r.payload);
        out_nxt.entry_count = fill_r[OUT_CNT_W-1:0];
        out_valid_nxt       = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hole_r   <= hole_nxt;
    best_r   <= best_nxt;
    mov_r    <= mov_nxt;
    best_e_r <= best_e_nxt;
    top_r    <= top_nxt;
    op_r     <= op_nxt;
    st_r     <= st_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.code == CMD_RESULT) |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");

  a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (fill_r == '0 || CNT_W'(ram_waddr) < fill_r))
    else $error("heap write beyond the filled region");

  a_refused_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.code == CMD_ACCEPT && (full || empty) &&
     ((in_data.operation == OP_INSERT && full) || (in_data.operation == OP_POP && empty)))
    |=> (fill_r == $past(fill_r)))
    else $error("refused item changed the fill count");
`endif

endmodule

@@ design/hpq_ctrl.sv @@
// controller of the heap queue: sequences accept, sift up, sift down and result hand-off
// depends on hpq_pkg
module hpq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hpq_pkg::hpq_stat_t stat,
  output hpq_pkg::hpq_cmd_t  cmd
);
  import hpq_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_UP   = 4'd2;
  localparam logic [3:0] S_UPC  = 4'd3;
  localparam logic [3:0] S_PT   = 4'd4;
  localparam logic [3:0] S_PL   = 4'd5;
  localparam logic [3:0] S_DL   = 4'd6;
  localparam logic [3:0] S_DR   = 4'd7;
  localparam logic [3:0] S_DC   = 4'd8;
  localparam logic [3:0] S_RES  = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.code  = CMD_IDLE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.code  = CMD_ACCEPT;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.code = CMD_DISP;
        priority if (stat.refuse) begin
          state_nxt = S_RES;
        end else if (stat.is_pop) begin
          state_nxt = S_PT;
        end else begin
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        cmd.code  = CMD_UP;
        state_nxt = stat.at_root ? S_RES : S_UPC;
      end
      S_UPC: begin
        cmd.code  = CMD_UP_CMP;
        state_nxt = stat.up_swap ? S_UP : S_RES;
      end
      S_PT: begin
        cmd.code  = CMD_POP_TOP;
        state_nxt = S_PL;
      end
      S_PL: begin
        cmd.code  = CMD_POP_LAST;
        state_nxt = S_DL;
      end
      S_DL: begin
        cmd.code  = CMD_DN_L;
        state_nxt = stat.dn_leaf ? S_RES : S_DR;
      end
      S_DR: begin
        cmd.code  = CMD_DN_R;
        state_nxt = S_DC;
      end
      S_DC: begin
        cmd.code  = CMD_DN_C;
        state_nxt = stat.dn_stay ? S_RES : S_DL;
      end
      S_RES: begin
        if (stat.out_free) begin
          cmd.code  = CMD_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
